// ===== rtl/text_console_cursor_scroll_top_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the text console block
// Concurrent checks clocked on the rising edge, disabled while in reset.
// ---------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CURSOR_SCROLL_TOP_MACROS_SVH
`define TEXT_CONSOLE_CURSOR_SCROLL_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// condition holds at every edge out of reset
`define TCC_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("tcc: invariant violated");

// antecedent implies consequent in the same cycle
`define TCC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tcc: implication violated");

// antecedent implies consequent in the following cycle
`define TCC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tcc: sequence violated");

`else

`define TCC_ASSERT_ALWAYS(label, clk, rst_n, cond)
`define TCC_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define TCC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/tcc_pkg.sv =====
// ---------------------------------------------------------------------------
// tcc_pkg
// Geometry, character codes, command codes and types of the text console.
// ---------------------------------------------------------------------------
`default_nettype none

package tcc_pkg;

    localparam int SCREEN_COLS = 80;
    localparam int SCREEN_ROWS = 25;
    localparam int CELL_COUNT  = SCREEN_COLS * SCREEN_ROWS;
    localparam int ADDR_W      = $clog2(CELL_COUNT);

    localparam int CMD_W  = 2;
    localparam int CHAR_W = 8;
    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int CELL_W = 2 * CHAR_W;

    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
    localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;
    localparam logic [CHAR_W-1:0] NUL_CHAR     = 8'h00;
    localparam logic [CHAR_W-1:0] RESET_COLOR  = 8'h0F;

    localparam logic [ROW_W-1:0]  ROWS_C    = ROW_W'(SCREEN_ROWS);
    localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(SCREEN_ROWS - 1);
    localparam logic [COL_W-1:0]  COLS_C    = COL_W'(SCREEN_COLS);
    localparam logic [ADDR_W-1:0] COLS_A    = ADDR_W'(SCREEN_COLS);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELL_COUNT - 1);
    // first cell of the bottom row, also where the scroll copy stops
    localparam logic [ADDR_W-1:0] LAST_ROW_BASE = ADDR_W'(CELL_COUNT - SCREEN_COLS);

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_SCROLL,
        ST_FILL
    } t_state;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col);
        cell_addr = ADDR_W'(row) * COLS_A + ADDR_W'(col);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/text_console_cursor_scroll_top.sv =====
// ---------------------------------------------------------------------------
// text_console_cursor_scroll_top
// 80x25 text console: cell store in one RAM, cursor, newline, wrap, scroll.
// ---------------------------------------------------------------------------
//  channel | direction | handshake                   | payload
//  --------+-----------+-----------------------------+---------------------------
//  in      | sink      | i_in_valid / o_in_ready     | command, char_code, row, col
//  out     | source    | o_out_valid / i_out_ready   | cell char/colour, cursor
//  cfg     | sink      | i_cfg_we (no wait)          | text colour byte
//
//  Plain writes and NUL stay in IDLE; a cell read goes through READ for the
//  registered RAM read. A scroll: read/write-back copy in SCROLL, then FILL
//  blanking the bottom row; a clear runs FILL over all cells. Input held off.
//  After reset a clearing pass over all CELL_COUNT (2000) cells runs before
//  the first transfer is taken; colour writes are accepted throughout.
//  The result register lets a new item in while the sink takes the last one.
// ---------------------------------------------------------------------------
`default_nettype none

`include "text_console_cursor_scroll_top_macros.svh"

module text_console_cursor_scroll_top (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [tcc_pkg::CHAR_W-1:0]  i_cfg_wdata,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic [tcc_pkg::CMD_W-1:0]   i_command,
    input  wire logic [tcc_pkg::CHAR_W-1:0]  i_char_code,
    input  wire logic [tcc_pkg::ROW_W-1:0]   i_read_row,
    input  wire logic [tcc_pkg::COL_W-1:0]   i_read_col,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic      [tcc_pkg::CHAR_W-1:0]  o_cell_char,
    output logic      [tcc_pkg::CHAR_W-1:0]  o_cell_color,
    output logic      [tcc_pkg::ROW_W-1:0]   o_cursor_row,
    output logic      [tcc_pkg::COL_W-1:0]   o_cursor_col
);

    tcc_pkg::t_state r_state, n_state;

    logic [tcc_pkg::ADDR_W-1:0] r_addr;
    logic [tcc_pkg::CHAR_W-1:0] r_text_color;
    logic [tcc_pkg::CHAR_W-1:0] r_fill_color;
    logic                       r_put_pending;
    logic [tcc_pkg::CHAR_W-1:0] r_put_char;
    logic [tcc_pkg::ROW_W-1:0]  r_row;
    logic [tcc_pkg::COL_W-1:0]  r_col;
    logic                       r_rd_hit;

    logic                       r_out_valid;
    logic [tcc_pkg::CHAR_W-1:0] r_out_char;
    logic [tcc_pkg::CHAR_W-1:0] r_out_color;
    logic [tcc_pkg::ROW_W-1:0]  r_out_row;
    logic [tcc_pkg::COL_W-1:0]  r_out_col;

    logic in_ready, accept;

    // step decode
    logic                       d_scroll, d_put, d_pend, d_rd_hit;
    logic [tcc_pkg::ROW_W-1:0]  d_row, put_row, row_next;
    logic [tcc_pkg::COL_W-1:0]  d_col, put_col;
    logic                       row_ok, wrap;

    // RAM port
    logic                       ram_we, ram_re;
    logic [tcc_pkg::ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [tcc_pkg::CELL_W-1:0] ram_wdata, ram_rdata;

    tcc_screen_ram #(
        .DEPTH (tcc_pkg::CELL_COUNT),
        .WIDTH (tcc_pkg::CELL_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign accept = i_in_valid && in_ready;

    // cursor movement for one command
    always_comb begin
        row_ok   = (r_row != tcc_pkg::LAST_ROW);
        row_next = r_row + 1'b1;
        wrap     = (r_col >= tcc_pkg::COLS_C);
        d_row    = r_row;
        d_col    = r_col;
        put_row  = r_row;
        put_col  = r_col;
        d_scroll = 1'b0;
        d_put    = 1'b0;
        d_pend   = 1'b0;
        d_rd_hit = (i_read_row < tcc_pkg::ROWS_C) && (i_read_col < tcc_pkg::COLS_C);
        if (i_command == tcc_pkg::CMD_WRITE) begin
            if (i_char_code == tcc_pkg::NEWLINE_CHAR) begin
                d_col = '0;
                if (row_ok) begin
                    d_row = row_next;
                end else begin
                    d_scroll = 1'b1;
                end
            end else if (i_char_code != tcc_pkg::NUL_CHAR) begin
                if (wrap) begin
                    put_col = '0;
                    if (row_ok) begin
                        put_row = row_next;
                        d_row   = row_next;
                        d_put   = 1'b1;
                    end else begin
                        // char lands on the fresh bottom row after the scroll
                        d_scroll = 1'b1;
                        d_pend   = 1'b1;
                    end
                end else begin
                    d_put = 1'b1;
                end
                d_col = put_col + 1'b1;
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tcc_pkg::ST_INIT: begin
                if (r_addr == tcc_pkg::LAST_ADDR) n_state = tcc_pkg::ST_IDLE;
            end
            tcc_pkg::ST_IDLE: begin
                if (accept) begin
                    case (i_command)
                        tcc_pkg::CMD_WRITE: if (d_scroll) n_state = tcc_pkg::ST_SCROLL;
                        tcc_pkg::CMD_CLEAR: n_state = tcc_pkg::ST_FILL;
                        tcc_pkg::CMD_READ:  n_state = tcc_pkg::ST_READ;
                        default:            n_state = tcc_pkg::ST_IDLE;
                    endcase
                end
            end
            tcc_pkg::ST_READ: begin
                n_state = tcc_pkg::ST_IDLE;
            end
            tcc_pkg::ST_SCROLL: begin
                if (r_addr == tcc_pkg::LAST_ROW_BASE) n_state = tcc_pkg::ST_FILL;
            end
            tcc_pkg::ST_FILL: begin
                if (r_addr == tcc_pkg::LAST_ADDR) n_state = tcc_pkg::ST_IDLE;
            end
            default: n_state = tcc_pkg::ST_INIT;
        endcase
    end

    // outputs: handshake and RAM port
    always_comb begin
        in_ready  = 1'b0;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_waddr = r_addr;
        ram_raddr = r_addr;
        ram_wdata = {tcc_pkg::BLANK_CHAR, r_fill_color};
        unique case (r_state)
            tcc_pkg::ST_IDLE: begin
                in_ready  = !r_out_valid || i_out_ready;
                ram_we    = accept && d_put;
                ram_waddr = tcc_pkg::cell_addr(put_row, put_col);
                ram_wdata = {i_char_code, r_text_color};
                ram_re    = accept && (i_command == tcc_pkg::CMD_READ) && d_rd_hit;
                ram_raddr = tcc_pkg::cell_addr(i_read_row, i_read_col);
            end
            tcc_pkg::ST_SCROLL: begin
                // read one row ahead, write back what was read last cycle
                ram_re    = (r_addr != tcc_pkg::LAST_ROW_BASE);
                ram_raddr = r_addr + tcc_pkg::COLS_A;
                ram_we    = (r_addr != '0);
                ram_waddr = r_addr - 1'b1;
                ram_wdata = ram_rdata;
            end
            tcc_pkg::ST_INIT, tcc_pkg::ST_FILL: begin
                ram_we = 1'b1;
                if (r_put_pending && (r_addr == tcc_pkg::LAST_ROW_BASE)) begin
                    ram_wdata = {r_put_char, r_fill_color};
                end
            end
            tcc_pkg::ST_READ: begin
                ram_we = 1'b0;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= tcc_pkg::ST_INIT;
            r_addr        <= '0;
            r_fill_color  <= tcc_pkg::RESET_COLOR;
            r_text_color  <= tcc_pkg::RESET_COLOR;
            r_put_pending <= 1'b0;
            r_row         <= '0;
            r_col         <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_text_color <= i_cfg_wdata;
            end

            case (r_state)
                tcc_pkg::ST_INIT, tcc_pkg::ST_FILL: begin
                    r_addr <= r_addr + 1'b1;
                    if (r_addr == tcc_pkg::LAST_ADDR) r_put_pending <= 1'b0;
                end
                tcc_pkg::ST_SCROLL: begin
                    // stop on the bottom row base, where the fill starts
                    if (r_addr != tcc_pkg::LAST_ROW_BASE) r_addr <= r_addr + 1'b1;
                end
                tcc_pkg::ST_IDLE: begin
                    if (accept) begin
                        r_addr        <= '0;
                        r_fill_color  <= r_text_color;
                        r_put_pending <= d_pend;
                        r_row         <= d_row;
                        r_col         <= d_col;
                    end
                end
                default: begin
                    r_addr <= r_addr;
                end
            endcase

            if (r_state == tcc_pkg::ST_READ) begin
                r_out_valid <= 1'b1;
            end else if (accept && (i_command != tcc_pkg::CMD_READ)) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_put_char <= i_char_code;
            r_rd_hit   <= d_rd_hit;
        end
        if (r_state == tcc_pkg::ST_READ) begin
            r_out_char  <= r_rd_hit ? ram_rdata[tcc_pkg::CELL_W-1:tcc_pkg::CHAR_W] : '0;
            r_out_color <= r_rd_hit ? ram_rdata[tcc_pkg::CHAR_W-1:0] : '0;
            r_out_row   <= r_row;
            r_out_col   <= r_col;
        end else if (accept && (i_command != tcc_pkg::CMD_READ)) begin
            r_out_char  <= '0;
            r_out_color <= '0;
            r_out_row   <= d_row;
            r_out_col   <= d_col;
        end
    end

    assign o_in_ready   = in_ready;
    assign o_out_valid  = r_out_valid;
    assign o_cell_char  = r_out_char;
    assign o_cell_color = r_out_color;
    assign o_cursor_row = r_out_row;
    assign o_cursor_col = r_out_col;

    `TCC_ASSERT_IMPL(a_read_slot_free, i_clk, i_rst_n, r_state == tcc_pkg::ST_READ, !r_out_valid)
    `TCC_ASSERT_ALWAYS(a_cursor_col_range, i_clk, i_rst_n, r_col <= tcc_pkg::COLS_C)
    `TCC_ASSERT_ALWAYS(a_cursor_row_range, i_clk, i_rst_n, r_row <= tcc_pkg::LAST_ROW)
    `TCC_ASSERT_IMPL(a_pending_in_sweep, i_clk, i_rst_n, r_put_pending,
        r_state == tcc_pkg::ST_SCROLL || r_state == tcc_pkg::ST_FILL)
    `TCC_ASSERT_NEXT(a_fill_ends_idle, i_clk, i_rst_n,
        r_state == tcc_pkg::ST_FILL && r_addr == tcc_pkg::LAST_ADDR,
        r_state == tcc_pkg::ST_IDLE && !r_put_pending)

endmodule

`default_nettype wire

// ===== rtl/tcc_screen_ram.sv =====
// ---------------------------------------------------------------------------
// tcc_screen_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module tcc_screen_ram #(
    parameter int DEPTH = 2000,
    parameter int WIDTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== tb/text_console_cursor_scroll_top_tb.sv =====
// ---------------------------------------------------------------------------
// text_console_cursor_scroll_top_tb
// Self-checking bench for the 80x25 text console. A queue-fed driver and a
// monitor run on the rising clock edge. A shadow screen, cursor and colour
// predict every result at the input transfer, and the monitor checks each
// output transfer field by field. Phases vary text colour, sender idling,
// receiver stalls and long receiver hold-offs.
// ---------------------------------------------------------------------------
module text_console_cursor_scroll_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [tcc_pkg::CMD_W-1:0]  t_cmd;
    typedef logic [tcc_pkg::CHAR_W-1:0] t_char;
    typedef logic [tcc_pkg::ROW_W-1:0]  t_row;
    typedef logic [tcc_pkg::COL_W-1:0]  t_col;

    localparam t_cmd CMD_SPARE      = 2'd3;
    localparam int   WATCHDOG_LIMIT = 20000;
    localparam int   REPORT_LIMIT   = 10;
    localparam int   PHASE_ITEMS    = 205;

    typedef struct packed {
        t_cmd  cmd;
        t_char code;
        t_row  row;
        t_col  col;
    } t_console_cmd;

    typedef struct packed {
        t_char ch;
        t_char attr;
        t_row  cur_row;
        t_col  cur_col;
    } t_console_result;

    logic  clk       = 1'b0;
    logic  rst_n     = 1'b0;
    logic  cfg_we    = 1'b0;
    t_char cfg_wdata = '0;
    logic  in_valid  = 1'b0;
    t_cmd  in_cmd    = '0;
    t_char in_char   = '0;
    t_row  in_row    = '0;
    t_col  in_col    = '0;
    logic  out_ready = 1'b0;
    logic  o_in_ready;
    logic  o_out_valid;
    t_char o_cell_char;
    t_char o_cell_color;
    t_row  o_cursor_row;
    t_col  o_cursor_col;

    // shadow of the console
    t_char shadow_char [tcc_pkg::CELL_COUNT];
    t_char shadow_attr [tcc_pkg::CELL_COUNT];
    t_row  shadow_row;
    t_col  shadow_col;
    t_char shadow_color;

    t_console_cmd    pending_cmds [$];
    t_console_result expected_results [$];

    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    bit  hold_off_on = 1'b0;
    int  hold_cycles = 0;
    int  hold_starts = 0;
    int  quiet_cycles = 0;
    int  mismatch_count = 0;

    text_console_cursor_scroll_top i_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_in_valid   (in_valid),
        .o_in_ready   (o_in_ready),
        .i_command    (in_cmd),
        .i_char_code  (in_char),
        .i_read_row   (in_row),
        .i_read_col   (in_col),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (out_ready),
        .o_cell_char  (o_cell_char),
        .o_cell_color (o_cell_color),
        .o_cursor_row (o_cursor_row),
        .o_cursor_col (o_cursor_col)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ---------------- prediction ----------------

    function automatic void blank_cells(int first, int last);
        int k;
        for (k = first; k <= last; k++) begin
            shadow_char[k] = tcc_pkg::BLANK_CHAR;
            shadow_attr[k] = shadow_color;
        end
    endfunction

    function automatic void line_feed();
        int k;
        shadow_col = '0;
        if (int'(shadow_row) + 1 < tcc_pkg::SCREEN_ROWS) begin
            shadow_row = shadow_row + 1'b1;
        end else begin
            for (k = 0; k < tcc_pkg::CELL_COUNT - tcc_pkg::SCREEN_COLS; k++) begin
                shadow_char[k] = shadow_char[k + tcc_pkg::SCREEN_COLS];
                shadow_attr[k] = shadow_attr[k + tcc_pkg::SCREEN_COLS];
            end
            blank_cells(tcc_pkg::CELL_COUNT - tcc_pkg::SCREEN_COLS, tcc_pkg::CELL_COUNT - 1);
        end
    endfunction

    function automatic t_console_result console_step(t_console_cmd c);
        t_console_result res;
        int idx;
        res = '0;
        case (c.cmd)
            tcc_pkg::CMD_WRITE: begin
                if (c.code == tcc_pkg::NEWLINE_CHAR) begin
                    line_feed();
                end else if (c.code != tcc_pkg::NUL_CHAR) begin
                    if (int'(shadow_col) >= tcc_pkg::SCREEN_COLS) line_feed();
                    idx = int'(shadow_row) * tcc_pkg::SCREEN_COLS + int'(shadow_col);
                    shadow_char[idx] = c.code;
                    shadow_attr[idx] = shadow_color;
                    shadow_col = shadow_col + 1'b1;
                end
            end
            tcc_pkg::CMD_CLEAR: blank_cells(0, tcc_pkg::CELL_COUNT - 1);
            tcc_pkg::CMD_READ: begin
                if (int'(c.row) < tcc_pkg::SCREEN_ROWS &&
                    int'(c.col) < tcc_pkg::SCREEN_COLS) begin
                    idx = int'(c.row) * tcc_pkg::SCREEN_COLS + int'(c.col);
                    res.ch   = shadow_char[idx];
                    res.attr = shadow_attr[idx];
                end
            end
            default: ;
        endcase
        res.cur_row = shadow_row;
        res.cur_col = shadow_col;
        return res;
    endfunction

    // ---------------- driver ----------------

    always @(posedge clk) begin : cmd_driver
        t_console_cmd c;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_in_ready) begin
                c.cmd  = in_cmd;
                c.code = in_char;
                c.row  = in_row;
                c.col  = in_col;
                expected_results.push_back(console_step(c));
            end
            if (!in_valid || o_in_ready) begin
                if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    c = pending_cmds.pop_front();
                    in_valid <= 1'b1;
                    in_cmd   <= c.cmd;
                    in_char  <= c.code;
                    in_row   <= c.row;
                    in_col   <= c.col;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: random stalls, plus long hold-offs to back the block up;
    // the first cycle of a hold-off phase always starts one
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready   <= 1'b0;
            hold_cycles <= 0;
        end else if (hold_cycles != 0) begin
            hold_cycles <= hold_cycles - 1;
            out_ready   <= 1'b0;
        end else if (hold_off_on && (hold_starts == 0 || $urandom_range(59) == 0)) begin
            hold_cycles <= $urandom_range(400, 200);
            hold_starts <= hold_starts + 1;
            out_ready   <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ---------------- monitor ----------------

    always @(posedge clk) begin : result_monitor
        t_console_result got;
        t_console_result want;
        if (rst_n && o_out_valid && out_ready) begin
            got.ch      = o_cell_char;
            got.attr    = o_cell_color;
            got.cur_row = o_cursor_row;
            got.cur_col = o_cursor_col;
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("%0t: unexpected result char=%h attr=%h cursor=%0d,%0d",
                             $realtime, got.ch, got.attr, got.cur_row, got.cur_col);
            end else begin
                want = expected_results.pop_front();
                if (got.ch != want.ch || got.attr != want.attr ||
                    got.cur_row != want.cur_row || got.cur_col != want.cur_col) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display({"%0t: mismatch exp char=%h attr=%h cursor=%0d,%0d",
                                  " got char=%h attr=%h cursor=%0d,%0d"}, $realtime,
                                 want.ch, want.attr, want.cur_row, want.cur_col,
                                 got.ch, got.attr, got.cur_row, got.cur_col);
                end
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && o_in_ready) || (o_out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ---------------- stimulus ----------------

    function automatic t_char rand_glyph();
        t_char g;
        do g = t_char'($urandom_range(255, 1)); while (g == tcc_pkg::NEWLINE_CHAR);
        return g;
    endfunction

    function automatic void push_cmd(t_cmd cmd, t_char code, t_row row, t_col col);
        t_console_cmd c;
        c.cmd  = cmd;
        c.code = code;
        c.row  = row;
        c.col  = col;
        pending_cmds.push_back(c);
    endfunction

    // write with junk in the unused address fields
    function automatic void push_char(t_char code);
        push_cmd(tcc_pkg::CMD_WRITE, code, t_row'($urandom()), t_col'($urandom()));
    endfunction

    function automatic void push_read(t_row row, t_col col);
        push_cmd(tcc_pkg::CMD_READ, t_char'($urandom()), row, col);
    endfunction

    function automatic void push_clear();
        push_cmd(tcc_pkg::CMD_CLEAR, t_char'($urandom()), t_row'($urandom()),
                 t_col'($urandom()));
    endfunction

    // mostly text lines of random content; reads, clears, line feeds and noise
    function automatic void push_random_traffic(int target);
        int count;
        int kind;
        int len;
        int k;
        count = 0;
        while (count < target) begin
            kind = $urandom_range(99);
            if (kind < 55) begin
                len = ($urandom_range(3) == 0) ? $urandom_range(85, 75) : $urandom_range(30);
                for (k = 0; k < len; k++) push_char(rand_glyph());
                count += len;
                if ($urandom_range(4) != 0) begin
                    push_char(tcc_pkg::NEWLINE_CHAR);
                    count++;
                end
            end else if (kind < 80) begin
                len = $urandom_range(4, 1);
                for (k = 0; k < len; k++) begin
                    if ($urandom_range(6) == 0)
                        push_read(t_row'($urandom_range(31)), t_col'($urandom_range(127)));
                    else
                        push_read(t_row'($urandom_range(tcc_pkg::SCREEN_ROWS - 1)),
                                  t_col'($urandom_range(tcc_pkg::SCREEN_COLS - 1)));
                end
                count += len;
            end else if (kind < 85) begin
                push_clear();
                count++;
            end else if (kind < 93) begin
                len = $urandom_range(3, 1);
                for (k = 0; k < len; k++) push_char(tcc_pkg::NEWLINE_CHAR);
                count += len;
            end else if (kind < 96) begin
                push_char(t_char'($urandom()));
                count++;
            end else if (kind < 98) begin
                push_char(tcc_pkg::NUL_CHAR);
                count++;
            end else begin
                push_cmd(CMD_SPARE, t_char'($urandom()), t_row'($urandom()),
                         t_col'($urandom()));
                count++;
            end
        end
    endfunction

    task automatic wait_drained();
        do @(negedge clk);
        while (pending_cmds.size() != 0 || in_valid || expected_results.size() != 0 ||
               !o_in_ready);
    endtask

    task automatic write_color(t_char color);
        @(posedge clk);
        cfg_we       <= 1'b1;
        cfg_wdata    <= color;
        shadow_color = color;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic run_phase(int idle_pct, int stall_pct, bit hold_off,
                             t_char color, bit wrap_first);
        int k;
        wait_drained();
        write_color(color);
        @(negedge clk);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        hold_off_on    = hold_off;
        if (wrap_first) begin
            // full line to wrap pending, newline on it, then a wrap by a glyph
            push_char(tcc_pkg::NEWLINE_CHAR);
            for (k = 0; k < tcc_pkg::SCREEN_COLS; k++) push_char(rand_glyph());
            push_char(tcc_pkg::NEWLINE_CHAR);
            for (k = 0; k <= tcc_pkg::SCREEN_COLS; k++) push_char(rand_glyph());
        end
        push_random_traffic(PHASE_ITEMS);
    endtask

    initial begin
        int k;
        for (k = 0; k < tcc_pkg::CELL_COUNT; k++) begin
            shadow_char[k] = tcc_pkg::BLANK_CHAR;
            shadow_attr[k] = tcc_pkg::RESET_COLOR;
        end
        shadow_row   = '0;
        shadow_col   = '0;
        shadow_color = tcc_pkg::RESET_COLOR;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset contents, edges of the read window, byte extremes
        wait_drained();
        write_color(8'hFF);
        @(negedge clk);
        push_read('0, '0);
        push_read(t_row'(tcc_pkg::SCREEN_ROWS - 1), t_col'(tcc_pkg::SCREEN_COLS - 1));
        push_read('1, '1);
        push_read(t_row'(tcc_pkg::SCREEN_ROWS), '0);
        push_read('0, t_col'(tcc_pkg::SCREEN_COLS));
        push_char(8'h41);
        push_char(8'hFF);
        push_char(8'h01);
        push_char(8'h80);
        push_char(tcc_pkg::NUL_CHAR);
        push_cmd(CMD_SPARE, '1, '1, '1);
        push_cmd(CMD_SPARE, '0, '0, '0);
        push_read('0, '0);
        push_read('0, 7'd3);
        push_read('0, 7'd4);
        push_char(tcc_pkg::NEWLINE_CHAR);
        push_char(8'h7E);
        push_read(5'd1, '0);
        push_clear();
        push_read(5'd1, '0);
        push_read('0, '0);
        push_char(8'h55);
        push_read(5'd1, 7'd1);

        run_phase(0,  0,  1'b0, 8'h00, 1'b1);
        run_phase(61, 0,  1'b0, t_char'($urandom()), 1'b0);
        run_phase(0,  61, 1'b0, 8'h0F, 1'b0);
        run_phase(17, 17, 1'b0, t_char'($urandom()), 1'b0);
        run_phase(0,  0,  1'b1, t_char'($urandom()), 1'b0);
        run_phase(0,  0,  1'b0, 8'hF0, 1'b0);

        wait_drained();
        hold_off_on = 1'b0;
        repeat (64) @(posedge clk);
        mismatch_count += expected_results.size();
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
